>>> hdl/mbrpeb_pkg.sv
package mbrpeb_pkg;

	localparam int DATA_W = 32;
	localparam int CYL_W = 14;
	localparam int HEAD_W = 8;
	localparam int DIV_STEPS = DATA_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DATA_W-1:0] RESERVED_SECTORS = 32'd32768;
	localparam int SECTORS_PER_TRACK = 63;
	localparam int CYL_LIMIT = 1024;
	localparam int HEAD_LIMIT = 256;
	localparam logic [7:0] TYPE_BYTE = 8'h07;
	localparam logic [7:0] CYL_HIGH_MASK = 8'hC0;

	// floor((x / n) / 63) > 1024 holds exactly when (x / n) >= 63 * 1025
	localparam logic [DATA_W-1:0] CYL_OVER = DATA_W'(SECTORS_PER_TRACK * (CYL_LIMIT + 1));

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2,
		ST_ABORT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_EVAL,
		S_DIV_END,
		S_DIV_TOT,
		S_DIV_BEG,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [CYL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

	// Head count: 16, doubling while the disk has more than 1024 cylinders,
	// 256 lowered to 255.
	function automatic logic [HEAD_W-1:0] head_count(input logic [DATA_W-1:0] total);
		logic [HEAD_W-1:0] n;
		logic              found;
		n = HEAD_W'(HEAD_LIMIT - 1);
		found = 1'b0;
		for (int k = 4; k < 8; k++) begin
			if (!found && ((total >> k) < CYL_OVER)) begin
				n = HEAD_W'(1 << k);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [CYL_W-1:0] cyl_size(input logic [HEAD_W-1:0] heads);
		return CYL_W'(heads) * CYL_W'(SECTORS_PER_TRACK);
	endfunction

endpackage

>>> hdl/mbrpeb_div.sv
module mbrpeb_div import mbrpeb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DATA_W-1:0]    dvd_q;
	logic [CYL_W-1:0]     rem_q;
	logic [CYL_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [CYL_W:0]       a0, a1;
	logic [CYL_W-1:0]     r1, r2;
	logic                 q1, q2;

	// two restoring steps per cycle
	always_comb begin
		a0 = {rem_q, dvd_q[DATA_W-1]};
		q1 = (a0 >= {1'b0, dsr_q});
		r1 = q1 ? CYL_W'(a0 - {1'b0, dsr_q}) : a0[CYL_W-1:0];
		a1 = {r1, dvd_q[DATA_W-2]};
		q2 = (a1 >= {1'b0, dsr_q});
		r2 = q2 ? CYL_W'(a1 - {1'b0, dsr_q}) : a1[CYL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend register fills with quotient bits as it shifts out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-3:0], q1, q2};
			rem_q <= r2;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

>>> hdl/mbr_partition_entry_builder.sv
// Used slot that passes: setup, evaluation, then three passes of the shared radix-4 divider
// (end cylinder, disk cylinders, start cylinder), then hand-off to the result register.
// Empty, aborted, underflow and overflow slots skip the divider; an end inside cylinder 0 stops
// after the first pass and an end beyond the disk after the second. One beat at a time: in_ready
// is high only while idle, so a new beat waits until the last one is through. The block takes a
// new beat while the last result waits in the result register. Async active-low reset clears table state.
module mbr_partition_entry_builder import mbrpeb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [DATA_W-1:0]   disk_sectors,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DATA_W-1:0]   partition_sectors,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          slot,
	output logic [1:0]          status,
	output logic                start_head,
	output logic [7:0]          start_sector_byte,
	output logic [7:0]          start_cylinder_byte,
	output logic [7:0]          system_type,
	output logic [7:0]          end_head,
	output logic [7:0]          end_sector_byte,
	output logic [7:0]          end_cylinder_byte,
	output logic [DATA_W-1:0]   start_lba,
	output logic [DATA_W-1:0]   sector_count
);

	state_t            state_q, state_d;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic [DATA_W-1:0] disk_q;
	logic [DATA_W-1:0] next_start_q;
	logic [1:0]        slot_cnt_q;
	logic              failed_q;
	logic              out_valid_q;

	logic [DATA_W-1:0] size_q;
	logic [HEAD_W-1:0] heads_q;
	logic [CYL_W-1:0]  cyl_q;
	logic [DATA_W-1:0] start_q;
	logic [DATA_W-1:0] count_q;
	logic [DATA_W-1:0] end_q;
	logic              pre_bad_q;
	status_t           stat_q;
	logic [DATA_W-1:0] equot_q;
	logic [DATA_W-1:0] bcyl_q;

	logic [1:0]        res_slot_q;
	status_t           res_status_q;
	logic              res_start_head_q;
	logic [7:0]        res_ssec_q, res_scyl_q, res_type_q;
	logic [7:0]        res_ehead_q, res_esec_q, res_ecyl_q;
	logic [DATA_W-1:0] res_lba_q, res_count_q;

	logic              in_fire, out_free, done_fire;
	logic              first_slot;
	logic [DATA_W:0]   start_ext, end_ext;
	logic [DATA_W-1:0] count_s;
	logic              under_s;
	logic [DATA_W-1:0] ecyl;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign done_fire = (state_q == S_DONE) && out_free;
	assign first_slot = (slot_cnt_q == 2'd0);
	assign ecyl = equot_q - 1'b1;

	// slot 0 reservation and end sum
	always_comb begin
		under_s   = first_slot && (size_q < RESERVED_SECTORS);
		start_ext = {1'b0, next_start_q} + (first_slot ? {1'b0, RESERVED_SECTORS} : '0);
		count_s   = first_slot ? size_q - RESERVED_SECTORS : size_q;
		end_ext   = {1'b0, start_ext[DATA_W-1:0]} + {1'b0, count_s};
	end

	mbrpeb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer: next state and divider issue
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = end_q;
		div_req.divisor  = cyl_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_SETUP;
			end
			S_SETUP: state_d = S_EVAL;
			S_EVAL: begin
				if (failed_q || size_q == '0 || pre_bad_q) begin
					state_d = S_DONE;
				end else begin
					div_req.start = 1'b1;
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient == '0) begin
						state_d = S_DONE;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = disk_q;
						state_d = S_DIV_TOT;
					end
				end
			end
			S_DIV_TOT: begin
				if (div_rsp.done) begin
					if (ecyl >= div_rsp.quotient) begin
						state_d = S_DONE;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = start_q;
						state_d = S_DIV_BEG;
					end
				end
			end
			S_DIV_BEG: begin
				if (div_rsp.done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table state, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q       <= '0;
			next_start_q <= '0;
			slot_cnt_q   <= '0;
			failed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) disk_q <= disk_sectors;
			if (done_fire) begin
				out_valid_q <= 1'b1;
				if (slot_cnt_q == 2'd3) begin
					slot_cnt_q   <= '0;
					next_start_q <= '0;
					failed_q     <= 1'b0;
				end else begin
					slot_cnt_q <= slot_cnt_q + 1'b1;
					if (stat_q == ST_INVALID) failed_q <= 1'b1;
					if (stat_q == ST_OK) next_start_q <= start_q + count_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the entry
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) size_q <= partition_sectors;
			end
			S_SETUP: begin
				heads_q   <= head_count(disk_q);
				cyl_q     <= cyl_size(head_count(disk_q));
				start_q   <= start_ext[DATA_W-1:0];
				count_q   <= count_s;
				end_q     <= end_ext[DATA_W-1:0];
				pre_bad_q <= under_s || end_ext[DATA_W];
			end
			S_EVAL: begin
				if (failed_q)             stat_q <= ST_ABORT;
				else if (size_q == '0)    stat_q <= ST_EMPTY;
				else if (pre_bad_q)       stat_q <= ST_INVALID;
				else                      stat_q <= ST_OK;
			end
			S_DIV_END: begin
				if (div_rsp.done) begin
					equot_q <= div_rsp.quotient;
					if (div_rsp.quotient == '0) stat_q <= ST_INVALID;
				end
			end
			S_DIV_TOT: begin
				if (div_rsp.done && ecyl >= div_rsp.quotient) stat_q <= ST_INVALID;
			end
			S_DIV_BEG: begin
				if (div_rsp.done) bcyl_q <= div_rsp.quotient;
			end
			default: begin
			end
		endcase
	end

	// result register; fields other than slot and status are zero unless ok
	always_ff @(posedge clk) begin
		if (done_fire) begin
			res_slot_q   <= slot_cnt_q;
			res_status_q <= stat_q;
			if (stat_q == ST_OK) begin
				res_start_head_q <= first_slot;
				res_ssec_q  <= (bcyl_q[9:2] & CYL_HIGH_MASK) | 8'd1;
				res_scyl_q  <= bcyl_q[7:0];
				res_type_q  <= TYPE_BYTE;
				res_ehead_q <= heads_q - 1'b1;
				res_esec_q  <= (ecyl[9:2] & CYL_HIGH_MASK) | 8'(SECTORS_PER_TRACK);
				res_ecyl_q  <= ecyl[7:0];
				res_lba_q   <= start_q;
				res_count_q <= count_q;
			end else begin
				res_start_head_q <= 1'b0;
				res_ssec_q  <= '0;
				res_scyl_q  <= '0;
				res_type_q  <= '0;
				res_ehead_q <= '0;
				res_esec_q  <= '0;
				res_ecyl_q  <= '0;
				res_lba_q   <= '0;
				res_count_q <= '0;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign slot                = res_slot_q;
	assign status              = res_status_q;
	assign start_head          = res_start_head_q;
	assign start_sector_byte   = res_ssec_q;
	assign start_cylinder_byte = res_scyl_q;
	assign system_type         = res_type_q;
	assign end_head            = res_ehead_q;
	assign end_sector_byte     = res_esec_q;
	assign end_cylinder_byte   = res_ecyl_q;
	assign start_lba           = res_lba_q;
	assign sector_count        = res_count_q;

	// divider finishes only while the sequencer waits on it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_END || state_q == S_DIV_TOT || state_q == S_DIV_BEG))
		else $error("divider result outside a divide state");

	// no new beat while the divider is running
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy)
		else $error("input ready while divider busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(status)
			&& $stable(start_lba))
		else $error("result changed while stalled");

	// ok entries always carry the type byte
	a_ok_type: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && stat_q == ST_OK |=> system_type == TYPE_BYTE && out_valid)
		else $error("ok entry without type byte");

endmodule
